// ===== rtl/otl_pkg.sv =====
package otl_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [4:0] t_kind;
    typedef logic [2:0] t_pend;

    typedef struct packed {
        t_kind kind;
        logic  last;
    } t_token;

    localparam t_kind TK_EOF       = 5'd0;
    localparam t_kind TK_HASH      = 5'd1;
    localparam t_kind TK_LPAREN    = 5'd2;
    localparam t_kind TK_RPAREN    = 5'd3;
    localparam t_kind TK_LBRACE    = 5'd4;
    localparam t_kind TK_RBRACE    = 5'd5;
    localparam t_kind TK_COMMA     = 5'd6;
    localparam t_kind TK_DOT       = 5'd7;
    localparam t_kind TK_SEMICOLON = 5'd8;
    localparam t_kind TK_SLASH     = 5'd9;
    localparam t_kind TK_STAR      = 5'd10;
    localparam t_kind TK_PLUS      = 5'd11;
    localparam t_kind TK_MINUS     = 5'd12;
    localparam t_kind TK_BANG      = 5'd13;
    localparam t_kind TK_BANG_EQ   = 5'd14;
    localparam t_kind TK_EQ        = 5'd15;
    localparam t_kind TK_EQ_EQ     = 5'd16;
    localparam t_kind TK_GT        = 5'd17;
    localparam t_kind TK_GE        = 5'd18;
    localparam t_kind TK_SHR       = 5'd19;
    localparam t_kind TK_LT        = 5'd20;
    localparam t_kind TK_LE        = 5'd21;
    localparam t_kind TK_SHL       = 5'd22;
    localparam t_kind TK_AND       = 5'd23;
    localparam t_kind TK_AND_EQ    = 5'd24;
    localparam t_kind TK_OR        = 5'd25;
    localparam t_kind TK_OR_EQ     = 5'd26;
    localparam t_kind TK_XOR       = 5'd27;
    localparam t_kind TK_XOR_EQ    = 5'd28;
    localparam t_kind TK_NOT       = 5'd29;
    localparam t_kind TK_ERROR     = 5'd30;

    localparam t_pend PEND_NONE = 3'd0;
    localparam t_pend PEND_BANG = 3'd1;
    localparam t_pend PEND_EQ   = 3'd2;
    localparam t_pend PEND_GT   = 3'd3;
    localparam t_pend PEND_LT   = 3'd4;
    localparam t_pend PEND_AND  = 3'd5;
    localparam t_pend PEND_OR   = 3'd6;
    localparam t_pend PEND_XOR  = 3'd7;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_CARET  = 8'h5E;

    function automatic t_pend pend_code(input logic [7:0] c);
        t_pend p;
        unique case (c)
            CH_BANG:  p = PEND_BANG;
            CH_EQ:    p = PEND_EQ;
            CH_GT:    p = PEND_GT;
            CH_LT:    p = PEND_LT;
            CH_AMP:   p = PEND_AND;
            CH_PIPE:  p = PEND_OR;
            CH_CARET: p = PEND_XOR;
            default:  p = PEND_NONE;
        endcase
        return p;
    endfunction

    function automatic t_kind single_char_kind(input logic [7:0] c);
        t_kind k;
        unique case (c)
            CH_HASH:   k = TK_HASH;
            CH_LPAREN: k = TK_LPAREN;
            CH_RPAREN: k = TK_RPAREN;
            CH_LBRACE: k = TK_LBRACE;
            CH_RBRACE: k = TK_RBRACE;
            CH_COMMA:  k = TK_COMMA;
            CH_DOT:    k = TK_DOT;
            CH_SEMI:   k = TK_SEMICOLON;
            CH_SLASH:  k = TK_SLASH;
            CH_STAR:   k = TK_STAR;
            CH_PLUS:   k = TK_PLUS;
            CH_MINUS:  k = TK_MINUS;
            CH_TILDE:  k = TK_NOT;
            default:   k = TK_ERROR;
        endcase
        return k;
    endfunction

    function automatic t_kind single_kind(input t_pend p);
        t_kind k;
        unique case (p)
            PEND_BANG: k = TK_BANG;
            PEND_EQ:   k = TK_EQ;
            PEND_GT:   k = TK_GT;
            PEND_LT:   k = TK_LT;
            PEND_AND:  k = TK_AND;
            PEND_OR:   k = TK_OR;
            PEND_XOR:  k = TK_XOR;
            default:   k = TK_EOF;
        endcase
        return k;
    endfunction

    function automatic t_kind with_eq_kind(input t_pend p);
        t_kind k;
        unique case (p)
            PEND_BANG: k = TK_BANG_EQ;
            PEND_EQ:   k = TK_EQ_EQ;
            PEND_GT:   k = TK_GE;
            PEND_LT:   k = TK_LE;
            PEND_AND:  k = TK_AND_EQ;
            PEND_OR:   k = TK_OR_EQ;
            PEND_XOR:  k = TK_XOR_EQ;
            default:   k = TK_EOF;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/otl_if.sv =====
interface otl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface otl_token_if;
    logic       valid;
    logic       ready;
    logic [4:0] token_kind;
    logic       last_of_run;

    modport source (output valid, output token_kind, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input last_of_run, output ready);
endinterface

// ===== rtl/operator_token_lexer.sv =====
// Operator and punctuation lexer with one character of lookahead.
// i_chr carries one source byte per request (char_code), or an end-of-input
// marker (end_of_input) that flushes a held operator and yields EOF.
// o_tok carries token kinds; last_of_run marks the final token caused by
// one input request.
// Each input request gives zero, one or two tokens. Tokens are written into
// a registered queue and appear on o_tok from its head; a held operator
// character gives its token only with the next request.
// Throughput: one input request per cycle while i_chr.ready is high, one
// token per cycle while o_tok.ready is high. A 4-entry token queue sits
// between the two sides; i_chr.ready is high while at most two tokens are
// queued, so a stream with occasional two-token requests runs at full rate
// and only back-to-back doubles or a stalled receiver drop it till drained.
// Reset clears the held operator and empties the queue.
// When the receiver stalls, the head token holds on o_tok until taken.
module operator_token_lexer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    otl_char_if.sink            i_chr,
    otl_token_if.source         o_tok
);

    otl_pkg::t_pend                    r_pend;
    otl_pkg::t_pend                    n_pend;
    otl_pkg::t_token                   r_q [otl_pkg::QUEUE_DEPTH];
    otl_pkg::t_token                   n_q [otl_pkg::QUEUE_DEPTH];
    logic [otl_pkg::QCNT_W-1:0]        r_cnt;
    logic [otl_pkg::QCNT_W-1:0]        n_cnt;
    logic [otl_pkg::QCNT_W-1:0]        base;
    logic [1:0]                        nres;
    logic [1:0]                        push_cnt;
    otl_pkg::t_token                   tok_a;
    otl_pkg::t_token                   tok_b;
    otl_pkg::t_pend                    code;
    logic                              accept;
    logic                              pop;
    logic                              combine;

    assign i_chr.ready       = (r_cnt <= otl_pkg::QCNT_W'(otl_pkg::QUEUE_DEPTH - 2));
    assign accept            = i_chr.valid && i_chr.ready;
    assign o_tok.valid       = (r_cnt != '0);
    assign o_tok.token_kind  = r_q[0].kind;
    assign o_tok.last_of_run = r_q[0].last;
    assign pop               = o_tok.valid && o_tok.ready;

    always_comb begin
        code    = otl_pkg::pend_code(i_chr.char_code);
        combine = (r_pend != otl_pkg::PEND_NONE) &&
                  ((i_chr.char_code == otl_pkg::CH_EQ) ||
                   (r_pend == otl_pkg::PEND_GT && i_chr.char_code == otl_pkg::CH_GT) ||
                   (r_pend == otl_pkg::PEND_LT && i_chr.char_code == otl_pkg::CH_LT));
        tok_a   = '{kind: otl_pkg::TK_EOF, last: 1'b1};
        tok_b   = '{kind: otl_pkg::TK_EOF, last: 1'b1};
        nres    = 2'd0;
        n_pend  = otl_pkg::PEND_NONE;
        if (i_chr.end_of_input) begin
            if (r_pend != otl_pkg::PEND_NONE) begin
                tok_a = '{kind: otl_pkg::single_kind(r_pend), last: 1'b0};
                nres  = 2'd2;
            end else begin
                nres  = 2'd1;
            end
        end else if (combine) begin
            if (i_chr.char_code == otl_pkg::CH_EQ) begin
                tok_a.kind = otl_pkg::with_eq_kind(r_pend);
            end else if (r_pend == otl_pkg::PEND_GT) begin
                tok_a.kind = otl_pkg::TK_SHR;
            end else begin
                tok_a.kind = otl_pkg::TK_SHL;
            end
            nres = 2'd1;
        end else if (code != otl_pkg::PEND_NONE) begin
            n_pend = code;
            if (r_pend != otl_pkg::PEND_NONE) begin
                tok_a.kind = otl_pkg::single_kind(r_pend);
                nres       = 2'd1;
            end
        end else if (r_pend != otl_pkg::PEND_NONE) begin
            tok_a      = '{kind: otl_pkg::single_kind(r_pend), last: 1'b0};
            tok_b.kind = otl_pkg::single_char_kind(i_chr.char_code);
            nres       = 2'd2;
        end else begin
            tok_a.kind = otl_pkg::single_char_kind(i_chr.char_code);
            nres       = 2'd1;
        end
    end

    always_comb begin
        push_cnt = accept ? nres : 2'd0;
        base     = r_cnt - otl_pkg::QCNT_W'(pop);
        n_q      = r_q;
        if (pop) begin
            for (int i = 0; i < otl_pkg::QUEUE_DEPTH - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
        end
        for (int i = 0; i < otl_pkg::QUEUE_DEPTH; i++) begin
            if (push_cnt != 2'd0 &&
                base[otl_pkg::QIDX_W-1:0] == otl_pkg::QIDX_W'(i)) begin
                n_q[i] = tok_a;
            end
            if (push_cnt == 2'd2 &&
                base[otl_pkg::QIDX_W-1:0] + otl_pkg::QIDX_W'(1) == otl_pkg::QIDX_W'(i)) begin
                n_q[i] = tok_b;
            end
        end
        n_cnt = base + otl_pkg::QCNT_W'(push_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= otl_pkg::PEND_NONE;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_pend <= n_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule
